FILE: sv/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared types and constants for the aabb broadphase slot table: action and
// status codes, controller states and the packing of the stream beats.
// ----------------------------------------------------------------------------
package abt_pkg;

	// default sizing
	localparam int SLOTS_DEF      = 64;
	localparam int COORD_BITS_DEF = 32;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 6;
	localparam int COORD_W  = 32;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 2;

	// input beat layout (tdata, lowest bit first)
	localparam int IN_SLOT_LO = 0;
	localparam int IN_MINX_LO = IN_SLOT_LO + SLOT_W;
	localparam int IN_MINY_LO = IN_MINX_LO + COORD_W;
	localparam int IN_MAXX_LO = IN_MINY_LO + COORD_W;
	localparam int IN_MAXY_LO = IN_MAXX_LO + COORD_W;
	localparam int IN_TAG_LO  = IN_MAXY_LO + COORD_W;
	localparam int IN_USED_W  = IN_TAG_LO + TAG_W;
	localparam int S_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout (tdata, lowest bit first)
	localparam int OUT_USED_W = SLOT_W + 2 * TAG_W;
	localparam int M_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD    = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_MOVE   = 3'd2,
		ACT_PAIR   = 3'd3,
		ACT_QUERY  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BAD  = 2'd2,
		STAT_NONE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RESP,
		S_ADD_WR,
		S_ROW_LD,
		S_SCAN,
		S_FLUSH
	} fsm_state_t;

endpackage

FILE: sv/aabb_broadphase_table_unit.sv
// ----------------------------------------------------------------------------
// aabb_broadphase_table_unit
// Slot table of 2D axis-aligned boxes with user tags: add, remove, move,
// pair scan of one row against later slots, and region query.
// ----------------------------------------------------------------------------
// Add, remove, move and rejected requests pass through a response state
// (S_RESP, or S_ADD_WR for an add that finds a slot) that registers the result beat once the
// output is free. Pair scan and region query read the box memory through its
// single read port, one slot per cycle while no match waits on an output still
// held by the consumer, up to the high-water mark. A scan emits one beat per
// overlapping slot, the final one with tlast set, or a single no-match beat.
// Overlap is inclusive on every edge.
// Boxes, tags and the free stack live in memories that need no clearing after
// reset; only the per-slot valid bits, the counters and the control flags are reset, so the
// block takes its first beat right after reset.
// ----------------------------------------------------------------------------
module aabb_broadphase_table_unit #(
	parameter int SLOTS      = abt_pkg::SLOTS_DEF,
	parameter int COORD_BITS = abt_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request side
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// slot, min_x, min_y, max_x, max_y, user_tag
	input  logic [abt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// action
	input  logic [abt_pkg::ACTION_W-1:0]  s_axis_tuser,
	// result side
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// handle_out, tag_a, tag_b
	output logic [abt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [abt_pkg::STATUS_W-1:0]  m_axis_tuser,
	output logic                         m_axis_tlast
);
	import abt_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int BOX_W = 4 * COORD_BITS;
	localparam logic [SLOT_W:0]  SLOTS_EXT = (SLOT_W + 1)'(SLOTS);
	localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

	// storage
	logic [BOX_W-1:0] box_mem [SLOTS];
	logic [TAG_W-1:0] tag_mem [SLOTS];
	logic [IDX_W-1:0] fs_mem  [SLOTS];

	// control registers
	fsm_state_t       state_q, state_d;
	logic [CNT_W-1:0] fd_q, fd_d;
	logic [CNT_W-1:0] hw_q, hw_d;
	logic [SLOTS-1:0] valid_q, valid_d;
	logic [CNT_W-1:0] scan_i_q, scan_i_d;
	logic             v_s1, v_d;
	logic             pend_valid_q, pend_valid_d;
	logic             m_valid_q, m_valid_d;

	// payload registers
	logic [IDX_W-1:0] idx_s1, idx_d;
	logic [IDX_W-1:0] pend_handle_q, pend_handle_d;
	logic [TAG_W-1:0] pend_taga_q, pend_taga_d;
	logic [TAG_W-1:0] pend_tagb_q, pend_tagb_d;
	status_t          m_status_q, m_status_d;
	logic [SLOT_W-1:0] m_handle_q, m_handle_d;
	logic [TAG_W-1:0] m_taga_q, m_taga_d;
	logic [TAG_W-1:0] m_tagb_q, m_tagb_d;
	logic             m_last_q, m_last_d;
	logic [BOX_W-1:0] ref_box_q, ref_box_d;
	logic [TAG_W-1:0] ref_tag_q, ref_tag_d;
	logic [IDX_W-1:0] handle_q, handle_d;
	logic             pop_q, pop_d;
	logic             pair_q, pair_d;
	status_t          rstat_q, rstat_d;

	// memory ports
	logic             box_we, tag_we, rd_en, fs_we, fs_re;
	logic [IDX_W-1:0] box_wa, rd_a, fs_wa, fs_ra;
	logic [BOX_W-1:0] box_wd;
	logic [IDX_W-1:0] fs_wd;
	logic [BOX_W-1:0] box_rd_q;
	logic [TAG_W-1:0] tag_rd_q;
	logic [IDX_W-1:0] fs_rd_q;

	// input beat fields
	action_t          in_act;
	logic [SLOT_W-1:0] in_slot;
	logic [IDX_W-1:0] in_idx;
	logic [BOX_W-1:0] in_box;
	logic [TAG_W-1:0] in_tag;
	logic             in_ok;

	// overlap compare
	logic signed [COORD_BITS-1:0] a_lx, a_ly, a_hx, a_hy;
	logic signed [COORD_BITS-1:0] b_lx, b_ly, b_hx, b_hy;
	logic             ovl, match_s1, out_free, issue;
	logic [IDX_W-1:0] add_h;

	// unpack the request beat, only the low coordinate bits are kept
	assign in_act  = action_t'(s_axis_tuser);
	assign in_slot = s_axis_tdata[IN_SLOT_LO +: SLOT_W];
	assign in_idx  = in_slot[IDX_W-1:0];
	assign in_tag  = s_axis_tdata[IN_TAG_LO +: TAG_W];
	assign in_box  = {s_axis_tdata[IN_MAXY_LO +: COORD_BITS],
	                  s_axis_tdata[IN_MAXX_LO +: COORD_BITS],
	                  s_axis_tdata[IN_MINY_LO +: COORD_BITS],
	                  s_axis_tdata[IN_MINX_LO +: COORD_BITS]};
	assign in_ok   = ({1'b0, in_slot} < SLOTS_EXT) && valid_q[in_idx];

	// reference box against the box just read
	assign a_lx = ref_box_q[0 +: COORD_BITS];
	assign a_ly = ref_box_q[COORD_BITS +: COORD_BITS];
	assign a_hx = ref_box_q[2*COORD_BITS +: COORD_BITS];
	assign a_hy = ref_box_q[3*COORD_BITS +: COORD_BITS];
	assign b_lx = box_rd_q[0 +: COORD_BITS];
	assign b_ly = box_rd_q[COORD_BITS +: COORD_BITS];
	assign b_hx = box_rd_q[2*COORD_BITS +: COORD_BITS];
	assign b_hy = box_rd_q[3*COORD_BITS +: COORD_BITS];
	assign ovl  = (a_lx <= b_hx) && (b_lx <= a_hx) && (a_ly <= b_hy) && (b_ly <= a_hy);

	assign match_s1 = v_s1 && valid_q[idx_s1] && ovl;
	assign out_free = !m_valid_q || m_axis_tready;
	assign issue    = scan_i_q < hw_q;
	assign add_h    = pop_q ? fs_rd_q : handle_q;

	// ports
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tdata  = M_TDATA_W'({m_tagb_q, m_taga_q, m_handle_q});

	// controller: next state, memory strobes and register updates
	always_comb begin
		state_d       = state_q;
		fd_d          = fd_q;
		hw_d          = hw_q;
		valid_d       = valid_q;
		scan_i_d      = scan_i_q;
		v_d           = v_s1;
		pend_valid_d  = pend_valid_q;
		m_valid_d     = m_valid_q;
		idx_d         = idx_s1;
		pend_handle_d = pend_handle_q;
		pend_taga_d   = pend_taga_q;
		pend_tagb_d   = pend_tagb_q;
		m_status_d    = m_status_q;
		m_handle_d    = m_handle_q;
		m_taga_d      = m_taga_q;
		m_tagb_d      = m_tagb_q;
		m_last_d      = m_last_q;
		ref_box_d     = ref_box_q;
		ref_tag_d     = ref_tag_q;
		handle_d      = handle_q;
		pop_d         = pop_q;
		pair_d        = pair_q;
		rstat_d       = rstat_q;
		box_we        = 1'b0;
		tag_we        = 1'b0;
		box_wa        = '0;
		box_wd        = in_box;
		rd_en         = 1'b0;
		rd_a          = '0;
		fs_we         = 1'b0;
		fs_wa         = '0;
		fs_wd         = in_idx;
		fs_re         = 1'b0;
		fs_ra         = '0;

		// consumer took the held beat
		if (m_valid_q && m_axis_tready) begin
			m_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					ref_box_d    = in_box;
					ref_tag_d    = in_tag;
					v_d          = 1'b0;
					pend_valid_d = 1'b0;
					rstat_d      = STAT_OK;
					state_d      = S_RESP;
					case (in_act)
						ACT_ADD: begin
							if (fd_q != '0) begin
								fs_re   = 1'b1;
								fs_ra   = IDX_W'(fd_q - CNT_ONE);
								fd_d    = fd_q - CNT_ONE;
								pop_d   = 1'b1;
								state_d = S_ADD_WR;
							end else if (hw_q < SLOTS_CNT) begin
								handle_d = hw_q[IDX_W-1:0];
								hw_d     = hw_q + CNT_ONE;
								pop_d    = 1'b0;
								state_d  = S_ADD_WR;
							end else begin
								rstat_d = STAT_FULL;
							end
						end
						ACT_REMOVE: begin
							if (in_ok) begin
								valid_d[in_idx] = 1'b0;
								fs_we = 1'b1;
								fs_wa = fd_q[IDX_W-1:0];
								fd_d  = fd_q + CNT_ONE;
							end else begin
								rstat_d = STAT_BAD;
							end
						end
						ACT_MOVE: begin
							if (in_ok) begin
								box_we = 1'b1;
								box_wa = in_idx;
							end else begin
								rstat_d = STAT_BAD;
							end
						end
						ACT_PAIR: begin
							if (in_ok) begin
								rd_en    = 1'b1;
								rd_a     = in_idx;
								scan_i_d = CNT_W'(in_idx) + CNT_ONE;
								pair_d   = 1'b1;
								state_d  = S_ROW_LD;
							end else begin
								rstat_d = STAT_BAD;
							end
						end
						ACT_QUERY: begin
							scan_i_d = '0;
							pair_d   = 1'b0;
							state_d  = S_SCAN;
						end
						default: begin
							rstat_d = STAT_BAD;
						end
					endcase
				end
			end

			// single result beat
			S_RESP: begin
				if (out_free) begin
					m_valid_d  = 1'b1;
					m_status_d = rstat_q;
					m_handle_d = '0;
					m_taga_d   = '0;
					m_tagb_d   = '0;
					m_last_d   = 1'b1;
					state_d    = S_IDLE;
				end
			end

			// store the new box in its slot and hand back the handle
			S_ADD_WR: begin
				if (out_free) begin
					box_we         = 1'b1;
					tag_we         = 1'b1;
					box_wa         = add_h;
					box_wd         = ref_box_q;
					valid_d[add_h] = 1'b1;
					m_valid_d      = 1'b1;
					m_status_d     = STAT_OK;
					m_handle_d     = SLOT_W'(add_h);
					m_taga_d       = '0;
					m_tagb_d       = '0;
					m_last_d       = 1'b1;
					state_d        = S_IDLE;
				end
			end

			// row box and tag become the reference of the pair scan
			S_ROW_LD: begin
				ref_box_d = box_rd_q;
				ref_tag_d = tag_rd_q;
				state_d   = S_SCAN;
			end

			// one slot per cycle, a match waits while the previous one is held
			S_SCAN: begin
				if (!(match_s1 && pend_valid_q && !out_free)) begin
					if (match_s1) begin
						if (pend_valid_q) begin
							m_valid_d  = 1'b1;
							m_status_d = STAT_OK;
							m_handle_d = SLOT_W'(pend_handle_q);
							m_taga_d   = pend_taga_q;
							m_tagb_d   = pend_tagb_q;
							m_last_d   = 1'b0;
						end
						pend_valid_d  = 1'b1;
						pend_handle_d = idx_s1;
						pend_taga_d   = pair_q ? ref_tag_q : tag_rd_q;
						pend_tagb_d   = pair_q ? tag_rd_q : '0;
					end
					v_d   = issue;
					idx_d = scan_i_q[IDX_W-1:0];
					if (issue) begin
						rd_en    = 1'b1;
						rd_a     = scan_i_q[IDX_W-1:0];
						scan_i_d = scan_i_q + CNT_ONE;
					end else if (!v_s1) begin
						state_d = S_FLUSH;
					end
				end
			end

			// last match, or the no-match beat
			S_FLUSH: begin
				if (out_free) begin
					m_valid_d    = 1'b1;
					m_last_d     = 1'b1;
					pend_valid_d = 1'b0;
					if (pend_valid_q) begin
						m_status_d = STAT_OK;
						m_handle_d = SLOT_W'(pend_handle_q);
						m_taga_d   = pend_taga_q;
						m_tagb_d   = pend_tagb_q;
					end else begin
						m_status_d = STAT_NONE;
						m_handle_d = '0;
						m_taga_d   = '0;
						m_tagb_d   = '0;
					end
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fd_q         <= '0;
			hw_q         <= '0;
			valid_q      <= '0;
			scan_i_q     <= '0;
			v_s1         <= 1'b0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			fd_q         <= fd_d;
			hw_q         <= hw_d;
			valid_q      <= valid_d;
			scan_i_q     <= scan_i_d;
			v_s1         <= v_d;
			pend_valid_q <= pend_valid_d;
			m_valid_q    <= m_valid_d;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1        <= idx_d;
		pend_handle_q <= pend_handle_d;
		pend_taga_q   <= pend_taga_d;
		pend_tagb_q   <= pend_tagb_d;
		m_status_q    <= m_status_d;
		m_handle_q    <= m_handle_d;
		m_taga_q      <= m_taga_d;
		m_tagb_q      <= m_tagb_d;
		m_last_q      <= m_last_d;
		ref_box_q     <= ref_box_d;
		ref_tag_q     <= ref_tag_d;
		handle_q      <= handle_d;
		pop_q         <= pop_d;
		pair_q        <= pair_d;
		rstat_q       <= rstat_d;
	end

	// box and tag memories, one write and one registered read port
	always_ff @(posedge clk) begin
		if (box_we) begin
			box_mem[box_wa] <= box_wd;
		end
		if (tag_we) begin
			tag_mem[box_wa] <= ref_tag_q;
		end
		if (rd_en) begin
			box_rd_q <= box_mem[rd_a];
			tag_rd_q <= tag_mem[rd_a];
		end
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (fs_we) begin
			fs_mem[fs_wa] <= fs_wd;
		end
		if (fs_re) begin
			fs_rd_q <= fs_mem[fs_ra];
		end
	end

endmodule

FILE: tb/sv/abt_table_monitor.sv
// ----------------------------------------------------------------------------
// abt_table_monitor
// Watches both stream channels of the aabb slot table. Every request beat is
// run through a local copy of the table (slots, tags, free stack, high-water
// mark) to build the result beats it must cause. Each result beat is checked
// field by field against the oldest beat still owed.
// ----------------------------------------------------------------------------
module abt_table_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	// slot, min_x, min_y, max_x, max_y, user_tag
	input  logic [abt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// action
	input  logic [abt_pkg::ACTION_W-1:0]   s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// handle_out, tag_a, tag_b
	input  logic [abt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// status
	input  logic [abt_pkg::STATUS_W-1:0]   m_axis_tuser,
	input  logic                           m_axis_tlast,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import abt_pkg::*;

	localparam int OUT_HANDLE_LO = 0;
	localparam int OUT_TAGA_LO   = OUT_HANDLE_LO + SLOT_W;
	localparam int OUT_TAGB_LO   = OUT_TAGA_LO + TAG_W;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] handle;
		logic [TAG_W-1:0]  tag_a;
		logic [TAG_W-1:0]  tag_b;
		logic              last;
	} result_beat_t;

	typedef struct {
		int lx;
		int ly;
		int hx;
		int hy;
	} box_t;

	// shadow of the slot table
	bit                live [SLOTS_DEF];
	box_t              boxes [SLOTS_DEF];
	logic [TAG_W-1:0]  tags [SLOTS_DEF];
	logic [SLOT_W-1:0] free_slots [SLOTS_DEF];
	int                free_top;
	int                high_mark;

	// result beats owed by the block, oldest first
	result_beat_t      owed_beats [$];

	// sign extend a corner from the low COORD_BITS bits
	function automatic int to_coord(logic [COORD_W-1:0] raw);
		logic [COORD_W-1:0] v;
		v = raw << (COORD_W - COORD_BITS_DEF);
		return int'($signed(v)) >>> (COORD_W - COORD_BITS_DEF);
	endfunction

	// inclusive on every edge, inverted boxes compared as given
	function automatic bit boxes_meet(box_t a, box_t b);
		return a.lx <= b.hx && b.lx <= a.hx && a.ly <= b.hy && b.ly <= a.hy;
	endfunction

	task automatic owe_beat(status_t st, logic [SLOT_W-1:0] h, logic [TAG_W-1:0] ta,
			logic [TAG_W-1:0] tb, logic lst);
		owed_beats.push_back('{st, h, ta, tb, lst});
	endtask

	// close a scan: mark the final match, or owe a single no-match beat
	task automatic close_scan(int hits);
		if (hits == 0) begin
			owe_beat(STAT_NONE, '0, '0, '0, 1'b1);
		end else begin
			owed_beats[owed_beats.size() - 1].last = 1'b1;
		end
	endtask

	// apply one request to the shadow table and queue the beats it causes
	task automatic apply_request(logic [ACTION_W-1:0] act, logic [S_TDATA_W-1:0] d);
		logic [SLOT_W-1:0] slot;
		logic [TAG_W-1:0]  tag;
		box_t              req;
		int                h;
		int                hits;
		int                i;
		slot   = d[IN_SLOT_LO +: SLOT_W];
		tag    = d[IN_TAG_LO +: TAG_W];
		req.lx = to_coord(d[IN_MINX_LO +: COORD_W]);
		req.ly = to_coord(d[IN_MINY_LO +: COORD_W]);
		req.hx = to_coord(d[IN_MAXX_LO +: COORD_W]);
		req.hy = to_coord(d[IN_MAXY_LO +: COORD_W]);
		hits   = 0;
		case (act)
			ACT_ADD: begin
				// freed slots first, newest first, then fresh ones
				h = -1;
				if (free_top > 0) begin
					free_top--;
					h = int'(free_slots[free_top]);
				end else if (high_mark < SLOTS_DEF) begin
					h = high_mark;
					high_mark++;
				end
				if (h < 0) begin
					owe_beat(STAT_FULL, '0, '0, '0, 1'b1);
				end else begin
					boxes[h] = req;
					tags[h]  = tag;
					live[h]  = 1'b1;
					owe_beat(STAT_OK, SLOT_W'(h), '0, '0, 1'b1);
				end
			end
			ACT_REMOVE: begin
				if (!live[slot]) begin
					owe_beat(STAT_BAD, '0, '0, '0, 1'b1);
				end else begin
					live[slot]           = 1'b0;
					free_slots[free_top] = slot;
					free_top++;
					owe_beat(STAT_OK, '0, '0, '0, 1'b1);
				end
			end
			ACT_MOVE: begin
				if (!live[slot]) begin
					owe_beat(STAT_BAD, '0, '0, '0, 1'b1);
				end else begin
					boxes[slot] = req;
					owe_beat(STAT_OK, '0, '0, '0, 1'b1);
				end
			end
			ACT_PAIR: begin
				if (!live[slot]) begin
					owe_beat(STAT_BAD, '0, '0, '0, 1'b1);
				end else begin
					for (i = int'(slot) + 1; i < high_mark; i++) begin
						if (live[i] && boxes_meet(boxes[slot], boxes[i])) begin
							owe_beat(STAT_OK, SLOT_W'(i), tags[slot], tags[i], 1'b0);
							hits++;
						end
					end
					close_scan(hits);
				end
			end
			ACT_QUERY: begin
				for (i = 0; i < high_mark; i++) begin
					if (live[i] && boxes_meet(req, boxes[i])) begin
						owe_beat(STAT_OK, SLOT_W'(i), tags[i], '0, 1'b0);
						hits++;
					end
				end
				close_scan(hits);
			end
			default: begin
				owe_beat(STAT_BAD, '0, '0, '0, 1'b1);
			end
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t ns  %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		errors++;
	endtask

	// compare result beats, then fold in request beats
	always @(posedge clk) begin
		result_beat_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS_DEF; k++) live[k] = 1'b0;
			free_top  = 0;
			high_mark = 0;
			owed_beats.delete();
			errors    = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_beats.size() == 0) begin
					report_mismatch("result beat with nothing owed", 64'(m_axis_tdata), '0);
				end else begin
					want = owed_beats.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
					if (m_axis_tdata[OUT_HANDLE_LO +: SLOT_W] !== want.handle)
						report_mismatch("handle_out",
							64'(m_axis_tdata[OUT_HANDLE_LO +: SLOT_W]), 64'(want.handle));
					if (m_axis_tdata[OUT_TAGA_LO +: TAG_W] !== want.tag_a)
						report_mismatch("tag_a", 64'(m_axis_tdata[OUT_TAGA_LO +: TAG_W]),
							64'(want.tag_a));
					if (m_axis_tdata[OUT_TAGB_LO +: TAG_W] !== want.tag_b)
						report_mismatch("tag_b", 64'(m_axis_tdata[OUT_TAGB_LO +: TAG_W]),
							64'(want.tag_b));
					if (m_axis_tlast !== want.last)
						report_mismatch("tlast", 64'(m_axis_tlast), 64'(want.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_request(s_axis_tuser, s_axis_tdata);
		end
		pending = owed_beats.size();
	end

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the aabb slot table. A directed opening covers
// empty-table scans, bad and free slots, double remove, unknown actions,
// extreme and inverted boxes, touching edges and free-slot reuse; the table
// is then filled past full, followed by a random mix of all actions whose
// balance of adds and removes shifts from segment to segment. Both sides
// idle at random. The monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import abt_pkg::*;

	localparam int TOTAL_ITEMS  = 460;
	localparam int FILL_ITEMS   = SLOTS_DEF;
	localparam int SEGMENT_LEN  = 40;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int MAX_GAP      = 12;

	// action codes the block does not define
	localparam logic [ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_RSVD_HI = 3'd7;

	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [COORD_W-1:0] lx;
		logic [COORD_W-1:0] ly;
		logic [COORD_W-1:0] hx;
		logic [COORD_W-1:0] hy;
	} corners_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [ACTION_W-1:0]  s_axis_tuser = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;
	logic                 m_axis_tlast;

	int errors;
	int pending;
	int sent = 0;
	int tx_calm = 0;
	int rx_calm = 0;
	int rx_wait = 0;
	int quiet_cycles = 0;

	aabb_broadphase_table_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	abt_table_monitor table_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.errors        (errors),
		.pending       (pending)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// idle cycles before a beat, with occasional runs of back-to-back beats
	function automatic int pick_gap(inout int calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [COORD_W-1:0] q16(int whole);
		return COORD_W'(whole <<< 16);
	endfunction

	// mostly boxes in a shared area so scans find matches, some wild ones
	function automatic corners_t make_box();
		corners_t bx;
		int       mode;
		int       x0;
		int       y0;
		int       w;
		int       h;
		mode = $urandom_range(0, 9);
		x0   = int'($urandom_range(0, 2000)) - 1000;
		y0   = int'($urandom_range(0, 2000)) - 1000;
		w    = $urandom_range(0, 1000);
		h    = $urandom_range(0, 1000);
		bx   = corners_t'{q16(x0), q16(y0), q16(x0 + w), q16(y0 + h)};
		if (mode == 0) begin
			bx = corners_t'{$urandom, $urandom, $urandom, $urandom};
		end else if (mode == 1) begin
			// inverted on both axes
			bx = corners_t'{bx.hx, bx.hy, bx.lx, bx.ly};
		end else if (mode == 2) begin
			// a point, touches only on edges
			bx.hx = bx.lx;
			bx.hy = bx.ly;
		end else if (mode >= 7) begin
			bx.lx[15:0] = 16'($urandom);
			bx.ly[15:0] = 16'($urandom);
			bx.hx[15:0] = 16'($urandom);
			bx.hy[15:0] = 16'($urandom);
		end
		return bx;
	endfunction

	// present one request beat and hold it until accepted
	task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] slot,
			input corners_t bx, input logic [TAG_W-1:0] tag);
		logic [S_TDATA_W-1:0] d;
		int                   gap;
		d = '0;
		d[IN_SLOT_LO +: SLOT_W]  = slot;
		d[IN_MINX_LO +: COORD_W] = bx.lx;
		d[IN_MINY_LO +: COORD_W] = bx.ly;
		d[IN_MAXX_LO +: COORD_W] = bx.hx;
		d[IN_MAXY_LO +: COORD_W] = bx.hy;
		d[IN_TAG_LO +: TAG_W]    = tag;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	// result side: stall a random number of cycles after each beat
	always @(posedge clk) begin
		int gap;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_wait       <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			gap = pick_gap(rx_calm);
			m_axis_tready <= (gap == 0);
			rx_wait       <= gap;
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
		end else begin
			rx_wait       <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[aabb_broadphase_table_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		corners_t                all_space;
		logic [ACTION_W-1:0]     act;
		int                      add_pct;
		int                      roll;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		all_space = corners_t'{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX};

		// empty table: scans, bad slots, unknown actions
		send_request(ACT_QUERY, 6'd0, all_space, 32'h0);
		send_request(ACT_PAIR, 6'd0, make_box(), 32'h0);
		send_request(ACT_REMOVE, 6'd5, make_box(), 32'h0);
		send_request(ACT_MOVE, 6'd63, make_box(), 32'h0);
		for (int a = int'(ACT_RSVD_LO); a <= int'(ACT_RSVD_HI); a++)
			send_request(ACTION_W'(a), 6'($urandom), make_box(), $urandom);

		// extreme box, two boxes touching at a corner, an inverted box
		send_request(ACT_ADD, 6'd0, all_space, 32'hffff_ffff);
		send_request(ACT_ADD, 6'd0, corners_t'{q16(0), q16(0), q16(10), q16(10)}, 32'h0);
		send_request(ACT_ADD, 6'd0, corners_t'{q16(10), q16(10), q16(20), q16(20)},
			32'ha5a5_5a5a);
		send_request(ACT_ADD, 6'd0, corners_t'{q16(20), q16(20), q16(5), q16(5)},
			32'h1234_5678);
		send_request(ACT_PAIR, 6'd0, make_box(), 32'h0);
		send_request(ACT_PAIR, 6'd1, make_box(), 32'h0);
		send_request(ACT_QUERY, 6'd0, corners_t'{q16(10), q16(10), q16(10), q16(10)}, 32'h0);

		// double remove, move of live and free slots, free-slot reuse order
		send_request(ACT_REMOVE, 6'd1, make_box(), 32'h0);
		send_request(ACT_REMOVE, 6'd1, make_box(), 32'h0);
		send_request(ACT_MOVE, 6'd2, corners_t'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX},
			32'h0);
		send_request(ACT_MOVE, 6'd1, make_box(), 32'h0);
		send_request(ACT_ADD, 6'd0, make_box(), $urandom);
		send_request(ACT_REMOVE, 6'd2, make_box(), 32'h0);
		send_request(ACT_REMOVE, 6'd3, make_box(), 32'h0);
		send_request(ACT_ADD, 6'd0, make_box(), $urandom);
		send_request(ACT_ADD, 6'd0, make_box(), $urandom);
		send_request(ACT_PAIR, 6'd63, make_box(), 32'h0);
		send_request(ACT_QUERY, 6'd0, corners_t'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN},
			32'h0);

		// fill the table and run past full
		repeat (FILL_ITEMS) send_request(ACT_ADD, 6'($urandom), make_box(), $urandom);

		// random mix, segments lean toward growing or shrinking the table
		add_pct = 35;
		while (sent < TOTAL_ITEMS) begin
			if (sent % SEGMENT_LEN == 0)
				add_pct = ($urandom_range(0, 1) != 0) ? 35 : 10;
			roll = $urandom_range(0, add_pct + 64);
			if (roll < add_pct)
				act = ACT_ADD;
			else if (roll < add_pct + 18)
				act = ACT_REMOVE;
			else if (roll < add_pct + 30)
				act = ACT_MOVE;
			else if (roll < add_pct + 48)
				act = ACT_PAIR;
			else if (roll < add_pct + 62)
				act = ACT_QUERY;
			else
				act = ACTION_W'($urandom_range(int'(ACT_RSVD_LO), int'(ACT_RSVD_HI)));
			send_request(act, 6'($urandom), make_box(), $urandom);
		end
		s_axis_tvalid <= 1'b0;

		// wait for every owed beat, then let the block settle
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("[aabb_broadphase_table_unit] OK");
		else
			$display("[aabb_broadphase_table_unit] ERROR");
		$finish;
	end

endmodule

FILE: files.f
sv/abt_pkg.sv
sv/aabb_broadphase_table_unit.sv
tb/sv/abt_table_monitor.sv
tb/sv/tb_top.sv
